// ===== rtl/core/hsmd_pkg.sv =====
// ----------------------------------------------------------------------------
// hsmd_pkg
// Shared types, constants and microcode field codes for the haptic
// spring-mass-damper core.
// ----------------------------------------------------------------------------
package hsmd_pkg;

  // field and coefficient widths
  localparam int unsigned IO_W            = 32;
  localparam int unsigned COEF_W          = 32;
  localparam int unsigned CFRAC           = 20;
  localparam int unsigned STATE_WIDTH_DEF = 48;

  // multiplier unit widths: 64-bit magnitude split into two 32-bit halves
  localparam int unsigned HALF_W = 32;
  localparam int unsigned MAG_W  = 2 * HALF_W;
  localparam int unsigned PROD_W = HALF_W + COEF_W;
  localparam int unsigned ACC_W  = MAG_W + COEF_W;
  localparam int unsigned Q_W    = ACC_W - CFRAC;

  // configuration port
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned IDX_W   = PADDR_W - 2;

  // microprogram
  localparam int unsigned        STEP_W    = 5;
  localparam logic [STEP_W-1:0]  STEP_IDLE = '0;

  // register reset values
  localparam logic [COEF_W-1:0] STIFFNESS_RST      = 32'd18641718;
  localparam logic [COEF_W-1:0] DAMPING_RST        = 32'd18642;
  localparam logic [COEF_W-1:0] STEP_TIME_RST      = 32'd1049;
  localparam logic [COEF_W-1:0] STIFFNESS_GAIN_RST = 32'd41396;
  localparam logic [COEF_W-1:0] DAMPING_GAIN_RST   = 32'd41;

  typedef enum logic [IDX_W-1:0] {
    REG_STIFFNESS      = 3'd0,
    REG_DAMPING        = 3'd1,
    REG_STEP_TIME      = 3'd2,
    REG_STIFFNESS_GAIN = 3'd3,
    REG_DAMPING_GAIN   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [COEF_W-1:0] stiffness;
    logic [COEF_W-1:0] damping;
    logic [COEF_W-1:0] step_time;
    logic [COEF_W-1:0] stiffness_gain;
    logic [COEF_W-1:0] damping_gain;
  } coef_t;

  // sequencer operation of a control word
  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_WAIT,
    SEQ_EMIT,
    SEQ_JUMP
  } seq_op_t;

  typedef enum logic [1:0] {
    ALU_NONE,
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  // datapath register select
  typedef enum logic [2:0] {
    SEL_POS,
    SEL_VEL,
    SEL_ANG,
    SEL_WVL,
    SEL_T0,
    SEL_T1,
    SEL_T2
  } sel_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_LOAD,
    MUL_LO,
    MUL_HI,
    MUL_SUM,
    MUL_FIN
  } mul_op_t;

  typedef enum logic [2:0] {
    COEF_K,
    COEF_B,
    COEF_T,
    COEF_KG,
    COEF_BG
  } coef_sel_t;

  // one microcode control word
  typedef struct packed {
    seq_op_t           seq_op;
    logic [STEP_W-1:0] jump_to;
    alu_op_t           alu_op;
    sel_t              alu_a;
    sel_t              alu_b;
    sel_t              alu_dst;
    mul_op_t           mul_op;
    sel_t              mul_src;
    coef_sel_t         mul_coef;
    logic              mul_torque;
    sel_t              mul_dst;
  } ctrl_t;

  // channel status seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic out_free;
  } seq_status_t;

  // handshake decisions made by the sequencer
  typedef struct packed {
    logic in_ready;
    logic take_in;
    logic emit;
  } seq_hs_t;

endpackage

// ===== rtl/core/hsmd_in_if.sv =====
// ----------------------------------------------------------------------------
// hsmd_in_if
// Wheel sample channel: measured angle and velocity with valid/ready.
// ----------------------------------------------------------------------------
interface hsmd_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [hsmd_pkg::IO_W-1:0]   wheel_angle;
  logic signed [hsmd_pkg::IO_W-1:0]   wheel_velocity;

  modport source (output valid, output wheel_angle, output wheel_velocity, input ready);
  modport sink   (input valid, input wheel_angle, input wheel_velocity, output ready);
endinterface

// ===== rtl/core/hsmd_out_if.sv =====
// ----------------------------------------------------------------------------
// hsmd_out_if
// Torque command channel: saturated torque and clip flag with valid/ready.
// ----------------------------------------------------------------------------
interface hsmd_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [hsmd_pkg::IO_W-1:0]   torque;
  logic                               saturated;

  modport source (output valid, output torque, output saturated, input ready);
  modport sink   (input valid, input torque, input saturated, output ready);
endinterface

// ===== rtl/core/hsmd_cfg.sv =====
// ----------------------------------------------------------------------------
// hsmd_cfg
// APB-style register bank holding the five Q12.20 coefficients.
// ----------------------------------------------------------------------------
module hsmd_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hsmd_pkg::PADDR_W-1:0]   paddr,
  input  logic [hsmd_pkg::PDATA_W-1:0]   pwdata,
  output logic [hsmd_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output hsmd_pkg::coef_t                coef
);

  hsmd_pkg::reg_idx_t idx;
  logic               wr;

  assign pready = 1'b1;
  assign idx    = hsmd_pkg::reg_idx_t'(paddr[hsmd_pkg::PADDR_W-1:2]);
  assign wr     = psel & penable & pwrite & pready;

  // register writes, unknown index ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      coef.stiffness      <= hsmd_pkg::STIFFNESS_RST;
      coef.damping        <= hsmd_pkg::DAMPING_RST;
      coef.step_time      <= hsmd_pkg::STEP_TIME_RST;
      coef.stiffness_gain <= hsmd_pkg::STIFFNESS_GAIN_RST;
      coef.damping_gain   <= hsmd_pkg::DAMPING_GAIN_RST;
    end else if (wr) begin
      case (idx)
        hsmd_pkg::REG_STIFFNESS:      coef.stiffness      <= pwdata;
        hsmd_pkg::REG_DAMPING:        coef.damping        <= pwdata;
        hsmd_pkg::REG_STEP_TIME:      coef.step_time      <= pwdata;
        hsmd_pkg::REG_STIFFNESS_GAIN: coef.stiffness_gain <= pwdata;
        hsmd_pkg::REG_DAMPING_GAIN:   coef.damping_gain   <= pwdata;
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      hsmd_pkg::REG_STIFFNESS:      prdata = coef.stiffness;
      hsmd_pkg::REG_DAMPING:        prdata = coef.damping;
      hsmd_pkg::REG_STEP_TIME:      prdata = coef.step_time;
      hsmd_pkg::REG_STIFFNESS_GAIN: prdata = coef.stiffness_gain;
      hsmd_pkg::REG_DAMPING_GAIN:   prdata = coef.damping_gain;
      default:                      prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/hsmd_sequencer.sv =====
// ----------------------------------------------------------------------------
// hsmd_sequencer
// Step counter and microcode ROM; one control word per step, with waits on
// the input and output channels and a jump back to the idle step.
// ----------------------------------------------------------------------------
module hsmd_sequencer (
  input  logic                   clk,
  input  logic                   rst,
  input  hsmd_pkg::seq_status_t  status,
  output hsmd_pkg::ctrl_t        ctrl,
  output hsmd_pkg::seq_hs_t      hs
);

  logic [hsmd_pkg::STEP_W-1:0] step;
  logic [hsmd_pkg::STEP_W-1:0] step_next;

  // microprogram: five multiplies, each load / low / high / sum / finish
  function automatic hsmd_pkg::ctrl_t urom(input logic [hsmd_pkg::STEP_W-1:0] s);
    hsmd_pkg::ctrl_t w;
    w = '0;
    case (s)
      5'd0: begin
        w.seq_op = hsmd_pkg::SEQ_WAIT;
      end
      // dpos = T * vel, err = angle - pos
      5'd1: begin
        w.mul_op   = hsmd_pkg::MUL_LOAD;
        w.mul_src  = hsmd_pkg::SEL_VEL;
        w.mul_coef = hsmd_pkg::COEF_T;
        w.alu_op   = hsmd_pkg::ALU_SUB;
        w.alu_a    = hsmd_pkg::SEL_ANG;
        w.alu_b    = hsmd_pkg::SEL_POS;
        w.alu_dst  = hsmd_pkg::SEL_T1;
      end
      5'd2:  w.mul_op = hsmd_pkg::MUL_LO;
      5'd3:  w.mul_op = hsmd_pkg::MUL_HI;
      5'd4:  w.mul_op = hsmd_pkg::MUL_SUM;
      5'd5: begin
        w.mul_op  = hsmd_pkg::MUL_FIN;
        w.mul_dst = hsmd_pkg::SEL_T0;
      end
      // kt = KG * err, pos = pos + dpos
      5'd6: begin
        w.mul_op   = hsmd_pkg::MUL_LOAD;
        w.mul_src  = hsmd_pkg::SEL_T1;
        w.mul_coef = hsmd_pkg::COEF_KG;
        w.alu_op   = hsmd_pkg::ALU_ADD;
        w.alu_a    = hsmd_pkg::SEL_POS;
        w.alu_b    = hsmd_pkg::SEL_T0;
        w.alu_dst  = hsmd_pkg::SEL_POS;
      end
      // spring stretch d1 = pos - angle
      5'd7: begin
        w.mul_op  = hsmd_pkg::MUL_LO;
        w.alu_op  = hsmd_pkg::ALU_SUB;
        w.alu_a   = hsmd_pkg::SEL_POS;
        w.alu_b   = hsmd_pkg::SEL_ANG;
        w.alu_dst = hsmd_pkg::SEL_T2;
      end
      5'd8:  w.mul_op = hsmd_pkg::MUL_HI;
      5'd9:  w.mul_op = hsmd_pkg::MUL_SUM;
      5'd10: begin
        w.mul_op  = hsmd_pkg::MUL_FIN;
        w.mul_dst = hsmd_pkg::SEL_T1;
      end
      // bt = BG * vel, partial vel + kt
      5'd11: begin
        w.mul_op   = hsmd_pkg::MUL_LOAD;
        w.mul_src  = hsmd_pkg::SEL_VEL;
        w.mul_coef = hsmd_pkg::COEF_BG;
        w.alu_op   = hsmd_pkg::ALU_ADD;
        w.alu_a    = hsmd_pkg::SEL_VEL;
        w.alu_b    = hsmd_pkg::SEL_T1;
        w.alu_dst  = hsmd_pkg::SEL_T1;
      end
      5'd12: w.mul_op = hsmd_pkg::MUL_LO;
      5'd13: w.mul_op = hsmd_pkg::MUL_HI;
      5'd14: w.mul_op = hsmd_pkg::MUL_SUM;
      5'd15: begin
        w.mul_op  = hsmd_pkg::MUL_FIN;
        w.mul_dst = hsmd_pkg::SEL_T0;
      end
      // new mass velocity
      5'd16: begin
        w.alu_op  = hsmd_pkg::ALU_SUB;
        w.alu_a   = hsmd_pkg::SEL_T1;
        w.alu_b   = hsmd_pkg::SEL_T0;
        w.alu_dst = hsmd_pkg::SEL_VEL;
      end
      // spring torque term, d2 = vel - wheel velocity
      5'd17: begin
        w.mul_op     = hsmd_pkg::MUL_LOAD;
        w.mul_src    = hsmd_pkg::SEL_T2;
        w.mul_coef   = hsmd_pkg::COEF_K;
        w.mul_torque = 1'b1;
        w.alu_op     = hsmd_pkg::ALU_SUB;
        w.alu_a      = hsmd_pkg::SEL_VEL;
        w.alu_b      = hsmd_pkg::SEL_WVL;
        w.alu_dst    = hsmd_pkg::SEL_T1;
      end
      5'd18: w.mul_op = hsmd_pkg::MUL_LO;
      5'd19: w.mul_op = hsmd_pkg::MUL_HI;
      5'd20: w.mul_op = hsmd_pkg::MUL_SUM;
      5'd21: begin
        w.mul_op  = hsmd_pkg::MUL_FIN;
        w.mul_dst = hsmd_pkg::SEL_T2;
      end
      // damper torque term
      5'd22: begin
        w.mul_op     = hsmd_pkg::MUL_LOAD;
        w.mul_src    = hsmd_pkg::SEL_T1;
        w.mul_coef   = hsmd_pkg::COEF_B;
        w.mul_torque = 1'b1;
      end
      5'd23: w.mul_op = hsmd_pkg::MUL_LO;
      5'd24: w.mul_op = hsmd_pkg::MUL_HI;
      5'd25: w.mul_op = hsmd_pkg::MUL_SUM;
      5'd26: begin
        w.mul_op  = hsmd_pkg::MUL_FIN;
        w.mul_dst = hsmd_pkg::SEL_T1;
      end
      // torque = -(t1 + t2), hand to output register
      5'd27: begin
        w.seq_op  = hsmd_pkg::SEQ_EMIT;
        w.jump_to = hsmd_pkg::STEP_IDLE;
        w.alu_a   = hsmd_pkg::SEL_T2;
        w.alu_b   = hsmd_pkg::SEL_T1;
      end
      default: begin
        w.seq_op  = hsmd_pkg::SEQ_JUMP;
        w.jump_to = hsmd_pkg::STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  assign ctrl = urom(step);

  // channel handshakes
  always_comb begin
    hs.in_ready = (ctrl.seq_op == hsmd_pkg::SEQ_WAIT);
    hs.take_in  = hs.in_ready & status.in_valid;
    hs.emit     = (ctrl.seq_op == hsmd_pkg::SEQ_EMIT) & status.out_free;
  end

  // next step
  always_comb begin
    case (ctrl.seq_op)
      hsmd_pkg::SEQ_NEXT: step_next = step + 1'b1;
      hsmd_pkg::SEQ_WAIT: step_next = status.in_valid ? step + 1'b1 : step;
      hsmd_pkg::SEQ_EMIT: step_next = status.out_free ? ctrl.jump_to : step;
      hsmd_pkg::SEQ_JUMP: step_next = ctrl.jump_to;
      default:            step_next = hsmd_pkg::STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= hsmd_pkg::STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== rtl/core/hsmd_mul.sv =====
// ----------------------------------------------------------------------------
// hsmd_mul
// Shared signed-by-unsigned multiply with truncation toward zero, alignment
// shift and saturation, in microcode load, low, high, sum and finish steps.
// ----------------------------------------------------------------------------
module hsmd_mul #(
  parameter int unsigned STATE_WIDTH = hsmd_pkg::STATE_WIDTH_DEF
) (
  input  logic                               clk,
  input  hsmd_pkg::mul_op_t                  mul_op,
  input  logic                               torque,
  input  logic signed [STATE_WIDTH-1:0]      src,
  input  logic [hsmd_pkg::COEF_W-1:0]        coef,
  output logic signed [STATE_WIDTH-1:0]      result,
  output logic                               clip
);

  localparam int unsigned TQ_SHIFT = STATE_WIDTH - 12;
  localparam int unsigned QW       = hsmd_pkg::Q_W;

  logic                                neg;
  logic                                tq_mode;
  logic [hsmd_pkg::MAG_W-1:0]          mag;
  logic [hsmd_pkg::COEF_W-1:0]         coef_r;
  logic [hsmd_pkg::PROD_W-1:0]         prod_lo;
  logic [hsmd_pkg::PROD_W-1:0]         prod_hi;
  logic [QW-1:0]                       q;

  logic [STATE_WIDTH-1:0]              src_abs;
  logic [hsmd_pkg::HALF_W-1:0]         mul_a;
  logic [hsmd_pkg::PROD_W-1:0]         prod;
  logic [hsmd_pkg::ACC_W-1:0]          acc;
  logic [QW-1:0]                       q_next;
  logic [QW-1:0]                       lim;
  logic                                over;
  logic [STATE_WIDTH-1:0]              q_clip;

  // magnitude of the operand
  assign src_abs = src[STATE_WIDTH-1] ? STATE_WIDTH'(-src) : STATE_WIDTH'(src);

  // one 32x32 multiplier, low half then high half
  assign mul_a = (mul_op == hsmd_pkg::MUL_HI) ? mag[hsmd_pkg::MAG_W-1:hsmd_pkg::HALF_W]
                                              : mag[hsmd_pkg::HALF_W-1:0];
  assign prod  = mul_a * coef_r;

  // partial product sum and alignment to the target format
  assign acc    = {prod_hi, hsmd_pkg::HALF_W'(0)} + hsmd_pkg::ACC_W'(prod_lo);
  assign q_next = tq_mode ? QW'(acc >> TQ_SHIFT) : QW'(acc >> hsmd_pkg::CFRAC);

  // saturation limit of the magnitude, one more on the negative side
  always_comb begin
    if (tq_mode) begin
      lim = (QW'(1) << (hsmd_pkg::IO_W - 1)) - QW'(!neg);
    end else begin
      lim = (QW'(1) << (STATE_WIDTH - 1)) - QW'(!neg);
    end
    over   = (q > lim);
    q_clip = over ? lim[STATE_WIDTH-1:0] : q[STATE_WIDTH-1:0];
    result = neg ? $signed(STATE_WIDTH'(0) - q_clip) : $signed(q_clip);
    clip   = over & tq_mode;
  end

  always_ff @(posedge clk) begin
    case (mul_op)
      hsmd_pkg::MUL_LOAD: begin
        neg     <= src[STATE_WIDTH-1];
        tq_mode <= torque;
        mag     <= hsmd_pkg::MAG_W'(src_abs);
        coef_r  <= coef;
      end
      hsmd_pkg::MUL_LO:  prod_lo <= prod;
      hsmd_pkg::MUL_HI:  prod_hi <= prod;
      hsmd_pkg::MUL_SUM: q       <= q_next;
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/hsmd_datapath.sv =====
// ----------------------------------------------------------------------------
// hsmd_datapath
// Mass state, working registers, saturating adder, multiplier unit and the
// torque output register, all driven by the current control word.
// ----------------------------------------------------------------------------
module hsmd_datapath #(
  parameter int unsigned STATE_WIDTH = hsmd_pkg::STATE_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  hsmd_pkg::ctrl_t                    ctrl,
  input  hsmd_pkg::seq_hs_t                  hs,
  input  hsmd_pkg::coef_t                    coef,
  input  logic signed [hsmd_pkg::IO_W-1:0]   wheel_angle,
  input  logic signed [hsmd_pkg::IO_W-1:0]   wheel_velocity,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic signed [hsmd_pkg::IO_W-1:0]   torque,
  output logic                               saturated,
  output logic                               out_free
);

  localparam int unsigned EXT_W = STATE_WIDTH + 1;
  localparam int unsigned SUM_W = hsmd_pkg::IO_W + 2;
  localparam logic [STATE_WIDTH-1:0] S_MAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
  localparam logic [STATE_WIDTH-1:0] S_MIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};
  localparam logic [hsmd_pkg::IO_W-1:0] T_MAX = {1'b0, {(hsmd_pkg::IO_W-1){1'b1}}};
  localparam logic [hsmd_pkg::IO_W-1:0] T_MIN = {1'b1, {(hsmd_pkg::IO_W-1){1'b0}}};

  logic signed [STATE_WIDTH-1:0] pos, pos_next;
  logic signed [STATE_WIDTH-1:0] vel, vel_next;
  logic signed [STATE_WIDTH-1:0] ang, ang_next;
  logic signed [STATE_WIDTH-1:0] wvl, wvl_next;
  logic signed [STATE_WIDTH-1:0] t0, t0_next;
  logic signed [STATE_WIDTH-1:0] t1, t1_next;
  logic signed [STATE_WIDTH-1:0] t2, t2_next;
  logic                          tflag, tflag_next;

  logic signed [STATE_WIDTH-1:0] opa, opb, msrc;
  logic signed [EXT_W-1:0]       alu_sum;
  logic signed [STATE_WIDTH-1:0] alu_res;
  logic [hsmd_pkg::COEF_W-1:0]   mcoef;
  logic signed [STATE_WIDTH-1:0] mul_res;
  logic                          mul_clip;

  logic signed [hsmd_pkg::IO_W-1:0] ta, tb;
  logic signed [SUM_W-1:0]          tsum;
  logic                             t_over;

  // register select
  function automatic logic signed [STATE_WIDTH-1:0] pick(
    input hsmd_pkg::sel_t s,
    input logic signed [STATE_WIDTH-1:0] p, v, a, w, r0, r1, r2
  );
    logic signed [STATE_WIDTH-1:0] r;
    case (s)
      hsmd_pkg::SEL_POS: r = p;
      hsmd_pkg::SEL_VEL: r = v;
      hsmd_pkg::SEL_ANG: r = a;
      hsmd_pkg::SEL_WVL: r = w;
      hsmd_pkg::SEL_T0:  r = r0;
      hsmd_pkg::SEL_T1:  r = r1;
      hsmd_pkg::SEL_T2:  r = r2;
      default:           r = '0;
    endcase
    return r;
  endfunction

  assign opa  = pick(ctrl.alu_a, pos, vel, ang, wvl, t0, t1, t2);
  assign opb  = pick(ctrl.alu_b, pos, vel, ang, wvl, t0, t1, t2);
  assign msrc = pick(ctrl.mul_src, pos, vel, ang, wvl, t0, t1, t2);

  // saturating add / subtract at state width
  always_comb begin
    if (ctrl.alu_op == hsmd_pkg::ALU_SUB) begin
      alu_sum = EXT_W'(opa) - EXT_W'(opb);
    end else begin
      alu_sum = EXT_W'(opa) + EXT_W'(opb);
    end
    if (alu_sum[EXT_W-1] != alu_sum[STATE_WIDTH-1]) begin
      alu_res = alu_sum[EXT_W-1] ? S_MIN : S_MAX;
    end else begin
      alu_res = alu_sum[STATE_WIDTH-1:0];
    end
  end

  // coefficient select
  always_comb begin
    case (ctrl.mul_coef)
      hsmd_pkg::COEF_K:  mcoef = coef.stiffness;
      hsmd_pkg::COEF_B:  mcoef = coef.damping;
      hsmd_pkg::COEF_T:  mcoef = coef.step_time;
      hsmd_pkg::COEF_KG: mcoef = coef.stiffness_gain;
      hsmd_pkg::COEF_BG: mcoef = coef.damping_gain;
      default:           mcoef = '0;
    endcase
  end

  hsmd_mul #(
    .STATE_WIDTH (STATE_WIDTH)
  ) u_mul (
    .clk    (clk),
    .mul_op (ctrl.mul_op),
    .torque (ctrl.mul_torque),
    .src    (msrc),
    .coef   (mcoef),
    .result (mul_res),
    .clip   (mul_clip)
  );

  // register file next values
  always_comb begin
    pos_next   = pos;
    vel_next   = vel;
    ang_next   = ang;
    wvl_next   = wvl;
    t0_next    = t0;
    t1_next    = t1;
    t2_next    = t2;
    tflag_next = tflag;
    if (hs.take_in) begin
      ang_next   = STATE_WIDTH'(wheel_angle) << (STATE_WIDTH - hsmd_pkg::IO_W);
      wvl_next   = STATE_WIDTH'(wheel_velocity) << (STATE_WIDTH - hsmd_pkg::IO_W);
      tflag_next = 1'b0;
    end
    if (ctrl.alu_op != hsmd_pkg::ALU_NONE) begin
      case (ctrl.alu_dst)
        hsmd_pkg::SEL_POS: pos_next = alu_res;
        hsmd_pkg::SEL_VEL: vel_next = alu_res;
        hsmd_pkg::SEL_ANG: ang_next = alu_res;
        hsmd_pkg::SEL_WVL: wvl_next = alu_res;
        hsmd_pkg::SEL_T0:  t0_next  = alu_res;
        hsmd_pkg::SEL_T1:  t1_next  = alu_res;
        hsmd_pkg::SEL_T2:  t2_next  = alu_res;
        default: ;
      endcase
    end
    if (ctrl.mul_op == hsmd_pkg::MUL_FIN) begin
      tflag_next = tflag | mul_clip;
      case (ctrl.mul_dst)
        hsmd_pkg::SEL_POS: pos_next = mul_res;
        hsmd_pkg::SEL_VEL: vel_next = mul_res;
        hsmd_pkg::SEL_ANG: ang_next = mul_res;
        hsmd_pkg::SEL_WVL: wvl_next = mul_res;
        hsmd_pkg::SEL_T0:  t0_next  = mul_res;
        hsmd_pkg::SEL_T1:  t1_next  = mul_res;
        hsmd_pkg::SEL_T2:  t2_next  = mul_res;
        default: ;
      endcase
    end
  end

  // mass state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      vel <= '0;
    end else begin
      pos <= pos_next;
      vel <= vel_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    ang   <= ang_next;
    wvl   <= wvl_next;
    t0    <= t0_next;
    t1    <= t1_next;
    t2    <= t2_next;
    tflag <= tflag_next;
  end

  // negated sum of the two torque terms, clamped to 32 bits
  always_comb begin
    ta     = opa[hsmd_pkg::IO_W-1:0];
    tb     = opb[hsmd_pkg::IO_W-1:0];
    tsum   = -SUM_W'(ta) - SUM_W'(tb);
    t_over = (tsum[SUM_W-1:hsmd_pkg::IO_W-1] != 3'b000) &&
             (tsum[SUM_W-1:hsmd_pkg::IO_W-1] != 3'b111);
  end

  assign out_free = !out_valid || out_ready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (hs.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hs.emit) begin
      torque    <= t_over ? (tsum[SUM_W-1] ? T_MIN : T_MAX) : tsum[hsmd_pkg::IO_W-1:0];
      saturated <= tflag | t_over;
    end
  end

endmodule

// ===== rtl/core/haptic_spring_mass_damper_core.sv =====
// ----------------------------------------------------------------------------
// haptic_spring_mass_damper_core
// Once per control tick, takes the wheel angle and velocity, advances a
// virtual mass on a spring and damper by one forward-Euler step and returns
// the coupling torque (signals Q16.16, coefficients Q12.20, mass state with
// 16 integer bits and STATE_WIDTH-16 fraction bits). A new sample is taken
// only once the torque of the last one sits in the output register. The
// tick's length is set by the five coefficient multiplies, which go one
// after another through a single 32x32 multiplier in five microcode steps
// each (operand load, low and high partial products, sum and align,
// saturate), plus the step that waits for the sample, the velocity update
// step and the step that hands the torque over. If the previous torque is
// still waiting in the output register at that last step, the sequencer
// holds there until it has been taken. The output register holds a finished
// torque while the next tick is already being computed. Registers sit at
// byte addresses 0, 4, 8, 12, 16 (stiffness, damping, step_time,
// stiffness_gain, damping_gain). The user must see that they are written
// only while idle; the block itself does not enforce it. Reset zeroes the
// mass state and needs no clearing pass.
// ----------------------------------------------------------------------------
module haptic_spring_mass_damper_core #(
  parameter int unsigned STATE_WIDTH = hsmd_pkg::STATE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  hsmd_in_if.sink                        sample,
  hsmd_out_if.source                     response,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hsmd_pkg::PADDR_W-1:0]   paddr,
  input  logic [hsmd_pkg::PDATA_W-1:0]   pwdata,
  output logic [hsmd_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  hsmd_pkg::coef_t       coef;
  hsmd_pkg::ctrl_t       ctrl;
  hsmd_pkg::seq_status_t status;
  hsmd_pkg::seq_hs_t     hs;
  logic                  out_free;

  // configuration registers
  hsmd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef    (coef)
  );

  // microcode sequencer
  assign status.in_valid = sample.valid;
  assign status.out_free = out_free;

  hsmd_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl),
    .hs     (hs)
  );

  assign sample.ready = hs.in_ready;

  // datapath
  hsmd_datapath #(
    .STATE_WIDTH (STATE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .hs             (hs),
    .coef           (coef),
    .wheel_angle    (sample.wheel_angle),
    .wheel_velocity (sample.wheel_velocity),
    .out_ready      (response.ready),
    .out_valid      (response.valid),
    .torque         (response.torque),
    .saturated      (response.saturated),
    .out_free       (out_free)
  );

endmodule
